FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ghsp_pkg.sv
package ghsp_pkg;

    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] HEX_LEN   = COUNT_W'(32);
    localparam logic [COUNT_W-1:0] HALF_LEN  = COUNT_W'(16);
    localparam logic [COUNT_W-1:0] NULL_LEN  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] ZERO_LEN  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(33);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    // "null" in lower case, one byte per position
    localparam logic [CHAR_W-1:0] NULL_WORD [4] = '{8'h6E, 8'h75, 8'h6C, 8'h6C};

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       null_hit;
        logic       is_zero;
    } char_info_t;

    typedef struct packed {
        logic [WORD_W-1:0] high_word;
        logic [WORD_W-1:0] low_word;
        logic              status;
    } result_t;

endpackage

FILE: rtl/ghsp_if.sv
interface ghsp_char_if import ghsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              no_char;
    logic              last;

    modport source (output valid, char_code, no_char, last, input ready);
    modport sink   (input valid, char_code, no_char, last, output ready);
endinterface

interface ghsp_result_if import ghsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] high_word;
    logic [WORD_W-1:0] low_word;
    logic              status;

    modport source (output valid, high_word, low_word, status, input ready);
    modport sink   (input valid, high_word, low_word, status, output ready);
endinterface

FILE: rtl/ghsp_char_decode.sv
module ghsp_char_decode import ghsp_pkg::*;
(
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [COUNT_W-1:0] pos,
    output char_info_t         info
);

    logic [CHAR_W-1:0] want;

    assign want = NULL_WORD[pos[1:0]];

    always_comb
    begin
        info.is_hex = 1'b1;
        info.nibble = 4'd0;
        if (char_code inside {[8'h30:8'h39]})
        begin
            info.nibble = char_code[3:0];
        end
        else if (char_code inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            // low nibble of 'a'/'A' is 1, so add 9 to reach 10
            info.nibble = char_code[3:0] + 4'd9;
        end
        else
        begin
            info.is_hex = 1'b0;
        end
        info.null_hit = (char_code == want) || (char_code == (want - CASE_DELTA));
        info.is_zero  = (char_code == CHAR_ZERO);
    end

endmodule

FILE: rtl/ghsp_string_acc.sv
module ghsp_string_acc import ghsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               no_char,
    input  logic               last,
    input  char_info_t         info,
    output logic [COUNT_W-1:0] pos,
    output result_t            res
);

    logic [COUNT_W-1:0] count_reg, count_upd, count_next;
    logic [WORD_W-1:0]  high_reg, high_upd, high_next;
    logic [WORD_W-1:0]  low_reg, low_upd, low_next;
    logic               bad_reg, bad_upd, bad_next;
    logic               null_reg, null_upd, null_next;
    logic               zero_reg, zero_upd, zero_next;

    assign pos = count_reg;

    // fold one character into the running string state
    always_comb
    begin
        count_upd = count_reg;
        high_upd  = high_reg;
        low_upd   = low_reg;
        bad_upd   = bad_reg;
        null_upd  = null_reg;
        zero_upd  = zero_reg;
        if (!no_char)
        begin
            if (count_reg < HEX_LEN)
            begin
                if (!info.is_hex)
                    bad_upd = 1'b1;
                if (count_reg < HALF_LEN)
                    high_upd = {high_reg[WORD_W-5:0], (info.is_hex ? info.nibble : 4'd0)};
                else
                    low_upd = {low_reg[WORD_W-5:0], (info.is_hex ? info.nibble : 4'd0)};
            end
            if (count_reg < NULL_LEN && !info.null_hit)
                null_upd = 1'b0;
            if (count_reg == '0)
                zero_upd = info.is_zero;
            if (count_reg < COUNT_SAT)
                count_upd = count_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        res.high_word = '0;
        res.low_word  = '0;
        res.status    = STATUS_INVALID;
        if (count_upd == HEX_LEN)
        begin
            if (!bad_upd)
            begin
                res.high_word = high_upd;
                res.low_word  = low_upd;
                res.status    = STATUS_OK;
            end
        end
        else if (count_upd == ZERO_LEN && zero_upd)
            res.status = STATUS_OK;
        else if (count_upd == NULL_LEN && null_upd)
            res.status = STATUS_OK;
    end

    // clear after the final character so the next string starts fresh
    always_comb
    begin
        count_next = count_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        bad_next   = bad_reg;
        null_next  = null_reg;
        zero_next  = zero_reg;
        if (step)
        begin
            if (last)
            begin
                count_next = '0;
                high_next  = '0;
                low_next   = '0;
                bad_next   = 1'b0;
                null_next  = 1'b1;
                zero_next  = 1'b0;
            end
            else
            begin
                count_next = count_upd;
                high_next  = high_upd;
                low_next   = low_upd;
                bad_next   = bad_upd;
                null_next  = null_upd;
                zero_next  = zero_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
            bad_reg   <= 1'b0;
            null_reg  <= 1'b1;
            zero_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            bad_reg   <= bad_next;
            null_reg  <= null_next;
            zero_reg  <= zero_next;
        end
    end

endmodule

FILE: rtl/guid_hex_string_parser_top.sv
// GUID hex string parser.
// chars (sink): one byte of a string per transaction, with no_char marking
// an item without a byte and last marking the end of the string.
// result (source): one transaction per string, after its last item, with
// the two 64-bit words and a status bit (0 ok, 1 invalid).
// A character is held in the input register; a last item that advances
// from there loads the result register, which raises result.valid, so its
// result transaction passes through the input and result registers.
// Throughput: one transaction per cycle on chars when not stalled; the input register,
// the per-character decode and the string accumulator form one pass.
// The result register lets the next string keep streaming while a result
// waits; only a last item stalls, when the result register is still full.
// Reset clears both valid flags and the string state, so the first item
// after reset starts a new string.
// A stalled result holds its value until result.ready is high.
`include "assert_macros.svh"

module guid_hex_string_parser_top import ghsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ghsp_char_if.sink          chars,
    ghsp_result_if.source      result
);

    // input register
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_no_char_reg;
    logic              s1_last_reg;
    logic              s1_go;

    // result register
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    logic [COUNT_W-1:0] pos;
    char_info_t         info;
    result_t            res;

    // a non-final character always advances; a final one needs room in the
    // result register
    assign s1_go = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign chars.ready = !s1_valid_reg || s1_go;

    ghsp_char_decode u_decode (
        .char_code (s1_char_reg),
        .pos       (pos),
        .info      (info)
    );

    ghsp_string_acc u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_go),
        .no_char (s1_no_char_reg),
        .last    (s1_last_reg),
        .info    (info),
        .pos     (pos),
        .res     (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (chars.ready)
            s1_valid_next = chars.valid;
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (s1_go && s1_last_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg    <= chars.char_code;
            s1_no_char_reg <= chars.no_char;
            s1_last_reg    <= chars.last;
        end
        if (s1_go && s1_last_reg)
            out_res_reg <= res;
    end

    assign result.valid     = out_valid_reg;
    assign result.high_word = out_res_reg.high_word;
    assign result.low_word  = out_res_reg.low_word;
    assign result.status    = out_res_reg.status;

    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, (s1_go && s1_last_reg), out_valid_reg,
                 "final character did not load a result")
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n,
                 (out_valid_reg && out_res_reg.status == STATUS_INVALID),
                 (out_res_reg.high_word == '0 && out_res_reg.low_word == '0),
                 "invalid result carries nonzero words")
    `ASSERT_IMPL(a_stall_only_full, clk, rst_n, (!chars.ready),
                 (s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready),
                 "input stalled without a pending result")

endmodule

FILE: verif/testbench.sv
module testbench;
    import ghsp_pkg::*;

    // One row of the directed script: a byte, its no_char and last marks, and,
    // where the answer is obvious, the result typed in by hand.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              blank;
        logic              eos;
        logic              pinned;
        result_t           want;
    } step_t;

    localparam result_t NULL_GUID = '{64'd0, 64'd0, STATUS_OK};
    localparam result_t BAD_GUID  = '{64'd0, 64'd0, STATUS_INVALID};
    localparam int      N_DIRECTED = 25;
    localparam int      N_ITEMS    = 1050;

    // Directed script. Rows with last set and pinned carry the typed-in
    // result; everything else goes through the predictor.
    localparam step_t SCRIPT [N_DIRECTED] = '{
        '{8'h30, 1'b0, 1'b1, 1'b1, NULL_GUID}, // "0" alone is the null GUID
        '{8'h30, 1'b1, 1'b1, 1'b1, BAD_GUID},  // empty string, byte must be ignored
        '{8'hA5, 1'b1, 1'b0, 1'b0, NULL_GUID}, // no character, not last: no effect
        '{8'h30, 1'b0, 1'b1, 1'b1, NULL_GUID}, // "0" right after that
        '{8'h4E, 1'b0, 1'b0, 1'b0, NULL_GUID}, // "NuLl", mixed case
        '{8'h75, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'h4C, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'h6C, 1'b0, 1'b1, 1'b1, NULL_GUID},
        '{8'h67, 1'b0, 1'b1, 1'b1, BAD_GUID},  // 'g' short form is not supported
        '{8'hFF, 1'b0, 1'b1, 1'b1, BAD_GUID},  // top byte value
        '{8'h00, 1'b0, 1'b1, 1'b1, BAD_GUID},  // bottom byte value
        '{8'h6E, 1'b0, 1'b0, 1'b0, NULL_GUID}, // "nUl" + 'l' with bit 7 set
        '{8'h55, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'h6C, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'hEC, 1'b0, 1'b1, 1'b1, BAD_GUID},
        '{8'h30, 1'b0, 1'b0, 1'b0, NULL_GUID}, // "00": wrong length
        '{8'h30, 1'b0, 1'b1, 1'b1, BAD_GUID},
        '{8'h6E, 1'b0, 1'b0, 1'b0, NULL_GUID}, // "nulls": one byte too many
        '{8'h75, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'h6C, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'h6C, 1'b0, 1'b0, 1'b0, NULL_GUID},
        '{8'h73, 1'b0, 1'b1, 1'b1, BAD_GUID},
        '{8'h30, 1'b0, 1'b0, 1'b0, NULL_GUID}, // "0" closed by an empty last item
        '{8'h00, 1'b1, 1'b1, 1'b1, NULL_GUID},
        '{8'h46, 1'b0, 1'b1, 1'b1, BAD_GUID}   // single hex digit: wrong length
    };

    logic clk;
    logic rst_n;

    ghsp_char_if   chars ();
    ghsp_result_if result ();

    guid_hex_string_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    // Predictor state for the string in flight.
    logic [COUNT_W-1:0] str_len      = '0;
    logic [WORD_W-1:0]  hi_digits    = '0;
    logic [WORD_W-1:0]  lo_digits    = '0;
    bit                 bad_char     = 1'b0;
    bit                 null_spelled = 1'b1;
    bit                 zero_lead    = 1'b0;

    // Results still owed by the DUT, oldest first.
    result_t pending_guids [$];

    int items_sent;
    int burst_left;
    int mismatches;
    int ok_results;
    int bad_results;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66)
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46)
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    // Fold one byte into the string state.
    task automatic absorb_char(input logic [CHAR_W-1:0] ch);
        logic [4:0]        hv;
        logic [CHAR_W-1:0] lc;
        hv = hex_digit(ch);
        if (str_len < HEX_LEN)
        begin
            if (!hv[4])
                bad_char = 1'b1;
            if (str_len < HALF_LEN)
                hi_digits = {hi_digits[WORD_W-5:0], hv[3:0]};
            else
                lo_digits = {lo_digits[WORD_W-5:0], hv[3:0]};
        end
        if (str_len < NULL_LEN)
        begin
            lc = NULL_WORD[str_len[1:0]];
            if (ch != lc && ch != lc - CASE_DELTA)
                null_spelled = 1'b0;
        end
        if (str_len == '0)
            zero_lead = (ch == CHAR_ZERO);
        if (str_len < COUNT_SAT)
            str_len = str_len + COUNT_W'(1);
    endtask

    // Decide the result of the finished string and start a fresh one.
    function automatic result_t close_string();
        result_t r;
        r = BAD_GUID;
        if (str_len == HEX_LEN)
        begin
            if (!bad_char)
                r = '{hi_digits, lo_digits, STATUS_OK};
        end
        else if (str_len == ZERO_LEN && zero_lead)
        begin
            r = NULL_GUID;
        end
        else if (str_len == NULL_LEN && null_spelled)
        begin
            r = NULL_GUID;
        end
        str_len      = '0;
        hi_digits    = '0;
        lo_digits    = '0;
        bad_char     = 1'b0;
        null_spelled = 1'b1;
        zero_lead    = 1'b0;
        return r;
    endfunction

    // Drive one transaction on chars and update the predictor once it is
    // accepted. The sender runs in bursts; at the end of a burst, drop valid
    // for a random gap.
    task automatic feed_char(input logic [CHAR_W-1:0] ch, input logic blank,
                             input logic eos, input logic pinned, input result_t want);
        result_t guess;
        if (burst_left == 0)
        begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // Now and then a long burst, so stretches without gaps occur too.
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 48);
        end
        burst_left--;
        chars.valid     <= 1'b1;
        chars.char_code <= ch;
        chars.no_char   <= blank;
        chars.last      <= eos;
        // Inputs and DUT state are stable from the falling edge on, so what
        // is seen here is what the next rising edge samples.
        @(negedge clk);
        while (!chars.ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        if (!blank)
            absorb_char(ch);
        if (eos)
        begin
            guess = close_string();
            pending_guids.push_back(pinned ? want : guess);
        end
    endtask

    // Hold the sender idle until every owed result has come back.
    task automatic drain_results();
        chars.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_guids.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_hex();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10)
            return 8'(8'h30 + d);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_non_hex();
        logic [CHAR_W-1:0] c;
        logic [4:0]        hv;
        hv = 5'h10;
        c  = '0;
        while (hv[4])
        begin
            c  = 8'($urandom_range(0, 255));
            hv = hex_digit(c);
        end
        return c;
    endfunction

    // Build one random string and stream it. Half of the strings are well formed
    // GUIDs with random content; the rest are near misses and noise.
    task automatic send_random_string();
        logic [CHAR_W-1:0] text [$];
        int                kind;
        int                len;
        int                sub;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            repeat (32) text.push_back(rand_hex());
        end
        else if (kind < 62)
        begin
            // GUID with corrupted digits, sometimes the 'g' short form
            repeat (32) text.push_back(rand_hex());
            repeat ($urandom_range(1, 3)) text[$urandom_range(0, 31)] = rand_non_hex();
            if ($urandom_range(0, 3) == 0)
                text[0] = $urandom_range(0, 1) ? 8'h67 : 8'h47;
        end
        else if (kind < 74)
        begin
            sub = $urandom_range(0, 4);
            case (sub)
                0: text.push_back(CHAR_ZERO);
                1, 2:
                begin
                    for (int k = 0; k < 4; k++)
                        text.push_back(NULL_WORD[k] -
                                       ($urandom_range(0, 1) ? CASE_DELTA : 8'h00));
                    if (sub == 2)
                        text[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
                end
                3: text.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    text.push_back($urandom_range(0, 1) ? CHAR_ZERO : 8'h67);
                    repeat ($urandom_range(0, 35)) text.push_back(rand_hex());
                end
            endcase
        end
        else if (kind < 86)
        begin
            // Hex strings around the valid length, overlong ones included
            len = $urandom_range(28, 40);
            repeat (len) text.push_back(rand_hex());
        end
        else
        begin
            len = $urandom_range(0, 40);
            repeat (len) text.push_back(8'($urandom_range(0, 255)));
        end

        if (text.size() == 0)
        begin
            feed_char(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, NULL_GUID);
        end
        else
        begin
            for (int i = 0; i < text.size(); i++)
            begin
                // Sprinkle in items that carry no character.
                if ($urandom_range(0, 11) == 0)
                    feed_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NULL_GUID);
                if (i != text.size() - 1)
                begin
                    feed_char(text[i], 1'b0, 1'b0, 1'b0, NULL_GUID);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    // Close the string with a separate empty item.
                    feed_char(text[i], 1'b0, 1'b0, 1'b0, NULL_GUID);
                    feed_char(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, NULL_GUID);
                end
                else
                begin
                    feed_char(text[i], 1'b0, 1'b1, 1'b0, NULL_GUID);
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result receiver: alternate between always ready, mostly ready and
    // mostly stalled, each for a random stretch.
    initial
    begin : result_sink
        int mode;
        int left;
        mode = 0;
        left = 0;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
                0:       result.ready <= 1'b1;
                1:       result.ready <= ($urandom_range(0, 3) != 0);
                default: result.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Check each result transaction against the oldest owed result. Sample
    // at the falling edge, where valid and ready already show the handshake
    // of the coming rising edge.
    always @(negedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_guids.size() == 0)
            begin
                $error("result transaction with no string pending: %h %h %b",
                       result.high_word, result.low_word, result.status);
                mismatches++;
            end
            else
            begin
                want = pending_guids.pop_front();
                if (result.high_word !== want.high_word)
                begin
                    $error("high_word: expected %h, got %h", want.high_word, result.high_word);
                    mismatches++;
                end
                if (result.low_word !== want.low_word)
                begin
                    $error("low_word: expected %h, got %h", want.low_word, result.low_word);
                    mismatches++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, result.status);
                    mismatches++;
                end
                if (want.status == STATUS_OK)
                    ok_results++;
                else
                    bad_results++;
            end
        end
    end

    initial
    begin
        bit paused;
        paused          = 1'b0;
        items_sent      = 0;
        burst_left      = 0;
        mismatches      = 0;
        ok_results      = 0;
        bad_results     = 0;
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.no_char   = 1'b0;
        chars.last      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed edge cases.
        for (int i = 0; i < N_DIRECTED; i++)
            feed_char(SCRIPT[i].ch, SCRIPT[i].blank, SCRIPT[i].eos,
                      SCRIPT[i].pinned, SCRIPT[i].want);
        drain_results();

        // Random strings; pause once halfway until the DUT has caught up.
        while (items_sent < N_ITEMS)
        begin
            if (!paused && items_sent >= N_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            send_random_string();
        end

        // Let the last results come out, then idle before finishing.
        chars.valid <= 1'b0;
        @(posedge clk);
        while (pending_guids.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d character transactions; checked %0d results (%0d ok, %0d invalid).",
                 items_sent, ok_results + bad_results, ok_results, bad_results);
        $display("Covered random-case GUIDs, bad digits, null spellings, odd lengths and noise.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
